FILE: design/mex_pkg.sv
package mex_pkg;

	localparam int WIDTH = 32;
	localparam int PROD_W = 2 * WIDTH;
	localparam int CNT_W = $clog2(PROD_W);

	typedef logic [WIDTH-1:0] word_t;

	typedef struct packed {
		logic  start;
		word_t a;
		word_t b;
		word_t m;
	} mm_req_t;

	typedef struct packed {
		logic  done;
		word_t rem;
	} mm_rsp_t;

endpackage

FILE: design/mex_modmul.sv
module mex_modmul (
	input  logic            clk,
	input  logic            arst_n,
	input  mex_pkg::mm_req_t req,
	output mex_pkg::mm_rsp_t rsp
);
	import mex_pkg::*;

	localparam logic [1:0] MM_IDLE = 2'd0;
	localparam logic [1:0] MM_MUL  = 2'd1;
	localparam logic [1:0] MM_RED  = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	word_t             a_q, b_q, m_q, rem_q;
	logic [PROD_W-1:0] prod_q;

	logic [WIDTH:0]    trial;
	logic [WIDTH:0]    m_ext;
	logic [WIDTH:0]    diff;
	word_t             rem_next;

	// one restoring step: shift in the next product bit, subtract if it fits
	always_comb begin
		trial = {rem_q, prod_q[PROD_W-1]};
		m_ext = {1'b0, m_q};
		diff  = trial - m_ext;
		if (trial >= m_ext) begin
			rem_next = diff[WIDTH-1:0];
		end else begin
			rem_next = trial[WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MM_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == MM_RED) && (cnt_q == CNT_W'(PROD_W - 1));
			unique case (state_q)
				MM_IDLE: begin
					if (req.start) begin
						state_q <= MM_MUL;
					end
				end
				MM_MUL: begin
					cnt_q   <= '0;
					state_q <= MM_RED;
				end
				MM_RED: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(PROD_W - 1)) begin
						state_q <= MM_IDLE;
					end
				end
				default: begin
					state_q <= MM_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == MM_IDLE && req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			m_q <= req.m;
		end
		if (state_q == MM_MUL) begin
			prod_q <= PROD_W'(a_q) * PROD_W'(b_q);
			rem_q  <= '0;
		end
		if (state_q == MM_RED) begin
			rem_q  <= rem_next;
			prod_q <= {prod_q[PROD_W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

FILE: design/modular_exponentiation.sv
// Modular exponentiation, right-to-left square-and-multiply.
// Input channel (in_valid/in_ready) carries base, exponent and modulus; the
// output channel (out_valid/out_ready) returns result and bad_modulus, one
// result per input transfer. A transfer is taken when valid and ready are high.
// in_ready is high only while the sequencer is idle; one item at a time.
// Every modular product goes through one shared unit: a 32x32 multiply into a
// register, then a one-bit-per-cycle restoring remainder over the 64-bit
// product. Products per item: 1 (base reduction) + popcount(exponent) + index
// of the exponent's top set bit, so up to about 64 products at WIDTH 32. A zero
// modulus skips the arithmetic and goes straight to the output state.
// A finished result sits in an output register; while it waits, the next item
// is accepted and worked on, and it only stalls at the end if out_ready is
// still low. Reset clears the sequencer and drops out_valid.
module modular_exponentiation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] base,
	input  logic [31:0] exponent,
	input  logic [31:0] modulus,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result,
	output logic        bad_modulus
);
	import mex_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_BASE = 3'd1;
	localparam logic [2:0] S_NEXT = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_SQR  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] state_q;
	word_t      acc_q, b_q, e_q, m_q;
	logic       bad_q;
	logic       out_valid_q;
	logic [31:0] result_q;
	logic       bad_out_q;

	mm_req_t    req;
	mm_rsp_t    rsp;
	logic       in_xfer;
	logic       out_free;
	word_t      base_w, mod_w;

	assign base_w   = base[WIDTH-1:0];
	assign mod_w    = modulus[WIDTH-1:0];
	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	mex_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_comb begin
		req.start = 1'b0;
		req.a     = acc_q;
		req.b     = b_q;
		req.m     = m_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer && mod_w != '0) begin
					req.start = 1'b1;
					req.a     = base_w;
					req.b     = WIDTH'(1);
					req.m     = mod_w;
				end
			end
			S_NEXT: begin
				if (e_q != '0) begin
					req.start = 1'b1;
					req.a     = e_q[0] ? acc_q : b_q;
				end
			end
			S_MUL: begin
				if (rsp.done && e_q[WIDTH-1:1] != '0) begin
					req.start = 1'b1;
					req.a     = b_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// output register frees up or is loaded when the receiver side allows it
			if (out_free) begin
				out_valid_q <= (state_q == S_OUT);
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= (mod_w == '0) ? S_OUT : S_BASE;
					end
				end
				S_BASE: begin
					if (rsp.done) begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (e_q == '0) begin
						state_q <= S_OUT;
					end else if (e_q[0]) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_SQR;
					end
				end
				S_MUL: begin
					if (rsp.done) begin
						state_q <= (e_q[WIDTH-1:1] == '0) ? S_OUT : S_SQR;
					end
				end
				S_SQR: begin
					if (rsp.done) begin
						state_q <= S_NEXT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					b_q   <= base_w;
					e_q   <= exponent[WIDTH-1:0];
					m_q   <= mod_w;
					bad_q <= (mod_w == '0);
					acc_q <= (mod_w == '0) ? '0 : WIDTH'(1);
				end
			end
			S_BASE: begin
				if (rsp.done) begin
					b_q <= rsp.rem;
				end
			end
			S_NEXT: begin
				// even bit: squaring starts now, so drop the bit here
				if (e_q != '0 && !e_q[0]) begin
					e_q <= e_q >> 1;
				end
			end
			S_MUL: begin
				if (rsp.done) begin
					acc_q <= rsp.rem;
					e_q   <= e_q >> 1;
				end
			end
			S_SQR: begin
				if (rsp.done) begin
					b_q <= rsp.rem;
				end
			end
			S_OUT: begin
				if (out_free) begin
					result_q  <= 32'(acc_q);
					bad_out_q <= bad_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign result      = result_q;
	assign bad_modulus = bad_out_q;

endmodule

FILE: tb/sv/modular_exponentiation_test.sv
`timescale 1ns / 100ps

module modular_exponentiation_test;
	import mex_pkg::*;

	localparam int CYCLE_LIMIT = 6_000_000;
	localparam int LONG_HOLD   = 3000;
	localparam int DRAIN_CYCLES = 100;

	typedef struct packed {
		word_t result;
		logic  bad_modulus;
	} power_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] base = '0;
	logic [31:0] exponent = '0;
	logic [31:0] modulus = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] result;
	logic        bad_modulus;

	power_t expected_powers[$];
	int     mismatches = 0;
	int     cycle_count = 0;
	bit     sender_idles = 1'b0;
	bit     receiver_idles = 1'b0;
	bit     long_hold_req = 1'b0;

	modular_exponentiation i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.base       (base),
		.exponent   (exponent),
		.modulus    (modulus),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result     (result),
		.bad_modulus(bad_modulus)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// right-to-left square-and-multiply, 64-bit intermediates
	function automatic power_t predict_power(word_t b, word_t e, word_t m);
		power_t      p;
		logic [63:0] acc;
		logic [63:0] sq;
		word_t       exp_left;
		p.result = '0;
		p.bad_modulus = 1'b0;
		if (m == '0) begin
			p.bad_modulus = 1'b1;
			return p;
		end
		acc = 64'd1;
		sq = {32'd0, b} % {32'd0, m};
		exp_left = e;
		while (exp_left != '0) begin
			if (exp_left[0])
				acc = (acc * sq) % {32'd0, m};
			exp_left = exp_left >> 1;
			sq = (sq * sq) % {32'd0, m};
		end
		p.result = acc[31:0];
		return p;
	endfunction

	function automatic word_t rand_bits(int w);
		if (w <= 0)
			return '0;
		return $urandom() >> (32 - w);
	endfunction

	task automatic send_item(word_t b, word_t e, word_t m);
		if (sender_idles && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		base <= b;
		exponent <= e;
		modulus <= m;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_powers.push_back(predict_power(b, e, m));
	endtask

	// receiver: short random stalls, or one long hold-off on request
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		power_t exp_p;
		if (arst_n && out_valid && out_ready) begin
			if (expected_powers.size() == 0) begin
				$display("%0t: unexpected transfer, result %h bad_modulus %b",
					$time, result, bad_modulus);
				mismatches++;
			end else begin
				exp_p = expected_powers.pop_front();
				if (result !== exp_p.result) begin
					$display("%0t: result expected %h actual %h",
						$time, exp_p.result, result);
					mismatches++;
				end
				if (bad_modulus !== exp_p.bad_modulus) begin
					$display("%0t: bad_modulus expected %b actual %b",
						$time, exp_p.bad_modulus, bad_modulus);
					mismatches++;
				end
			end
		end
	end

	task automatic test_zero_modulus();
		send_item(32'd5, 32'd3, 32'd0);
		send_item(32'd0, 32'd0, 32'd0);
		send_item(32'hffff_ffff, 32'hffff_ffff, 32'd0);
	endtask

	task automatic test_zero_exponent();
		send_item(32'd7, 32'd0, 32'd13);
		send_item(32'd123, 32'd0, 32'd1);
		send_item(32'd0, 32'd0, 32'hffff_ffff);
	endtask

	task automatic test_modulus_one();
		send_item(32'hffff_ffff, 32'd5, 32'd1);
		send_item(32'd0, 32'hffff_ffff, 32'd1);
	endtask

	task automatic test_extremes();
		send_item(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_item(32'd0, 32'hffff_ffff, 32'hffff_ffff);
		send_item(32'hffff_ffff, 32'd1, 32'hffff_fffe);
		send_item(32'hffff_fffe, 32'hffff_ffff, 32'hffff_ffff);
		send_item(32'd1, 32'hffff_ffff, 32'h8000_0001);
		send_item(32'd2, 32'h8000_0000, 32'hffff_fffb);
		send_item(32'd13, 32'd13, 32'd13);      // base equals modulus
		send_item(32'hdead_beef, 32'h5555_aaaa, 32'd2);
	endtask

	task automatic send_random_item();
		word_t b;
		word_t e;
		word_t m;
		int    w;
		b = $urandom();
		e = rand_bits($urandom_range(0, 32));
		case ($urandom_range(0, 24))
			0: m = '0;
			1: m = 32'd1;
			default: begin
				w = $urandom_range(2, 32);
				m = rand_bits(w) | (32'd1 << (w - 1));
			end
		endcase
		send_item(b, e, m);
	endtask

	task automatic test_random_traffic();
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		repeat (200) send_random_item();
	endtask

	// hold the output long enough that a finished result waits, a second one
	// completes behind it and the input has to stall
	task automatic test_output_backpressure();
		sender_idles = 1'b0;
		long_hold_req = 1'b1;
		repeat (6)
			send_item($urandom(), $urandom_range(1, 7), $urandom() | 32'h8000_0000);
	endtask

	task automatic test_back_to_back();
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		repeat (50) send_random_item();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_modulus();
		test_zero_exponent();
		test_modulus_one();
		test_extremes();
		test_random_traffic();
		test_output_backpressure();
		test_back_to_back();
		in_valid <= 1'b0;
		while (expected_powers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: modular_exponentiation.f
design/mex_pkg.sv
design/mex_modmul.sv
design/modular_exponentiation.sv
tb/sv/modular_exponentiation_test.sv
